// ===== design/rai_pkg.sv =====
// ----------------------------------------------------------------------------
// rai_pkg
// Types and constants shared by the router alert inserter modules.
// ----------------------------------------------------------------------------
package rai_pkg;

	localparam logic [7:0] OPT_TYPE  = 8'h94;
	localparam logic [7:0] OPT_LEN   = 8'h04;
	localparam int unsigned OPT_BYTES = 4;

	localparam logic [5:0] MIN_HDR_BYTES = 6'd20;

	// header byte positions that are rewritten
	localparam logic [5:0] IDX_VER     = 6'd0;
	localparam logic [5:0] IDX_TLEN_HI = 6'd2;
	localparam logic [5:0] IDX_TLEN_LO = 6'd3;
	localparam logic [5:0] IDX_CK_HI   = 6'd10;
	localparam logic [5:0] IDX_CK_LO   = 6'd11;

	localparam logic [1:0] ST_INSERTED  = 2'd0;
	localparam logic [1:0] ST_MAXIMAL   = 2'd1;
	localparam logic [1:0] ST_MALFORMED = 2'd2;

	localparam int unsigned Q_DEPTH = 4;

	typedef enum logic [1:0] {
		CMD_PASS  = 2'd0,
		CMD_HDR   = 2'd1,
		CMD_TRUNC = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data;
		logic        last;
		logic [1:0]  status;
		logic [5:0]  count;
		logic [21:0] acc;
		logic [15:0] w0;
		logic [15:0] w1;
	} cmd_t;

	typedef struct packed {
		logic       en;
		logic [5:0] addr;
		logic [7:0] data;
	} mem_wr_t;

endpackage

// ===== design/rai_if.sv =====
// ----------------------------------------------------------------------------
// rai_if
// Byte stream channels of the router alert inserter.
// ----------------------------------------------------------------------------
interface rai_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface rai_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic [1:0] status;

	modport source (output valid, output out_byte, output out_last, output status,
		input ready);
	modport sink (input valid, input out_byte, input out_last, input status,
		output ready);
endinterface

// ===== design/rai_queue.sv =====
// ----------------------------------------------------------------------------
// rai_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module rai_queue
	import rai_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t pop_data,
	output logic empty
);

	localparam int QAW = $clog2(Q_DEPTH);
	localparam int QCW = $clog2(Q_DEPTH + 1);

	cmd_t           entries_q [Q_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;

	assign full     = (count_q == QCW'(Q_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

endmodule

// ===== design/rai_front.sv =====
// ----------------------------------------------------------------------------
// rai_front
// Accepts packet bytes, checks the header length, buffers the header and
// sums it, and queues pass, header and truncation commands.
// ----------------------------------------------------------------------------
module rai_front
	import rai_pkg::*;
#(
	parameter int MAX_HEADER_BYTES = 60
) (
	input  logic         clk,
	input  logic         arst_n,
	rai_in_if.sink       pkt_in,
	output mem_wr_t      mem_wr,
	output logic         q_push,
	output cmd_t         q_data,
	input  logic         q_full,
	input  logic         hdr_done,
	output logic         hdr_pending
);

	logic [5:0]  bc_q;
	logic [5:0]  hb_q;
	logic [21:0] acc_q;
	logic        pay_q;
	logic [1:0]  st_q;
	logic        pend_q;
	logic [7:0]  b0_q, b1_q, b2_q, b3_q;

	logic        acc_en;
	logic [7:0]  b;
	logic        last;
	logic [5:0]  hb_cur;
	logic [5:0]  hb_eff;
	logic        first;
	logic        short_hdr;
	logic        bad;
	logic [1:0]  bad_st;
	logic        pass;
	logic        skip;
	logic [21:0] addend;
	logic [21:0] acc_n;
	logic [5:0]  bc_n;
	logic        hdr_full;

	assign b      = pkt_in.in_byte;
	assign last   = pkt_in.in_last;
	assign hb_cur = {b[3:0], 2'b00};
	assign first  = (bc_q == 6'd0);
	assign hb_eff = first ? hb_cur : hb_q;

	assign short_hdr = (hb_cur < MIN_HDR_BYTES);
	assign bad = first && (short_hdr ||
		(({1'b0, hb_cur} + 7'(OPT_BYTES)) > 7'(MAX_HEADER_BYTES)));
	assign bad_st = short_hdr ? ST_MALFORMED : ST_MAXIMAL;
	assign pass   = pay_q || bad;

	// new header bytes wait until the previous header has been read out
	assign pkt_in.ready = !q_full && (pay_q || !pend_q);
	assign acc_en       = pkt_in.valid && pkt_in.ready;
	assign hdr_pending  = pend_q;

	assign skip = (bc_q <= IDX_TLEN_LO) || (bc_q == IDX_CK_HI) || (bc_q == IDX_CK_LO);
	assign addend = bc_q[0] ? {14'd0, b} : {6'd0, b, 8'd0};
	assign acc_n  = skip ? acc_q : acc_q + addend;
	assign bc_n     = bc_q + 6'd1;
	assign hdr_full = !(bc_n < hb_eff);

	always_comb begin
		q_data.kind   = CMD_PASS;
		q_data.data   = b;
		q_data.last   = last;
		q_data.status = pay_q ? st_q : bad_st;
		q_data.count  = bc_n;
		q_data.acc    = acc_n;
		q_data.w0     = {b0_q[7:4], b0_q[3:0] + 4'd1, b1_q};
		q_data.w1     = {b2_q, b3_q} + 16'(OPT_BYTES);
		if (!pass) begin
			if (hdr_full) begin
				q_data.kind   = CMD_HDR;
				q_data.status = ST_INSERTED;
			end else begin
				q_data.kind   = CMD_TRUNC;
				q_data.status = ST_MALFORMED;
			end
		end
	end

	assign q_push = acc_en && (pass || hdr_full || last);

	assign mem_wr.en   = acc_en && !pass;
	assign mem_wr.addr = bc_q;
	assign mem_wr.data = b;

	always_ff @(posedge clk) begin
		if (acc_en && !pass) begin
			unique case (bc_q)
				6'd0: b0_q <= b;
				6'd1: b1_q <= b;
				6'd2: b2_q <= b;
				6'd3: b3_q <= b;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q   <= '0;
			hb_q   <= '0;
			acc_q  <= '0;
			pay_q  <= 1'b0;
			st_q   <= ST_INSERTED;
			pend_q <= 1'b0;
		end else begin
			if (hdr_done) begin
				pend_q <= 1'b0;
			end
			if (acc_en) begin
				if (pass) begin
					if (last) begin
						bc_q  <= '0;
						hb_q  <= '0;
						acc_q <= '0;
						pay_q <= 1'b0;
						st_q  <= ST_INSERTED;
					end else if (!pay_q) begin
						pay_q <= 1'b1;
						st_q  <= bad_st;
					end
				end else if (hdr_full || last) begin
					pend_q <= 1'b1;
					bc_q   <= '0;
					hb_q   <= '0;
					acc_q  <= '0;
					st_q   <= ST_INSERTED;
					pay_q  <= hdr_full && !last;
				end else begin
					bc_q  <= bc_n;
					hb_q  <= hb_eff;
					acc_q <= acc_n;
				end
			end
		end
	end

endmodule

// ===== design/rai_back.sv =====
// ----------------------------------------------------------------------------
// rai_back
// Holds the header buffer and turns queued commands into output items:
// passed bytes, rewritten or truncated header, router alert option.
// ----------------------------------------------------------------------------
module rai_back
	import rai_pkg::*;
#(
	parameter int MAX_HEADER_BYTES = 60
) (
	input  logic         clk,
	input  logic         arst_n,
	rai_out_if.source    pkt_out,
	input  mem_wr_t      mem_wr,
	input  logic         q_empty,
	output logic         q_pop,
	input  cmd_t         q_data,
	input  logic [15:0]  alert_value,
	output logic         hdr_done
);

	localparam int AW = $clog2(MAX_HEADER_BYTES);

	typedef enum logic [2:0] {
		G_IDLE = 3'b001,
		G_HDR  = 3'b010,
		G_OPT  = 3'b100
	} gen_state_t;

	logic [7:0]  hdr_mem [MAX_HEADER_BYTES];

	gen_state_t  state_q;
	logic [5:0]  idx_q;
	logic [5:0]  cnt_q;
	logic        trunc_q;
	logic        last_q;
	logic [15:0] w0_q;
	logic [15:0] w1_q;
	logic [22:0] sum_q;
	logic [15:0] ck_q;

	logic        s1_v, s1_mem, s1_last;
	logic [7:0]  s1_byte, rd_s1;
	logic [1:0]  s1_st;

	logic        ov_q, ol_q;
	logic [7:0]  ob_q;
	logic [1:0]  os_q;

	logic        adv;
	logic        hdr_end;
	logic        g_v, g_mem, g_last, g_rd;
	logic [7:0]  g_byte;
	logic [1:0]  g_st;
	logic [16:0] fold1, fold2;

	assign adv     = !ov_q || pkt_out.ready;
	assign hdr_end = ((idx_q + 6'd1) == cnt_q);
	assign q_pop   = adv && (state_q == G_IDLE) && !q_empty;
	assign hdr_done = adv && (state_q == G_HDR) && hdr_end;
	assign g_rd    = (state_q == G_HDR);

	always_comb begin
		g_v    = 1'b0;
		g_mem  = 1'b0;
		g_last = 1'b0;
		g_byte = q_data.data;
		g_st   = ST_INSERTED;
		unique case (state_q)
			G_IDLE: begin
				if (!q_empty && q_data.kind == CMD_PASS) begin
					g_v    = 1'b1;
					g_last = q_data.last;
					g_st   = q_data.status;
				end
			end
			G_HDR: begin
				g_v    = 1'b1;
				g_mem  = 1'b1;
				g_last = trunc_q && hdr_end;
				g_st   = trunc_q ? ST_MALFORMED : ST_INSERTED;
				if (!trunc_q) begin
					case (idx_q)
						IDX_VER:     begin g_mem = 1'b0; g_byte = w0_q[15:8]; end
						IDX_TLEN_HI: begin g_mem = 1'b0; g_byte = w1_q[15:8]; end
						IDX_TLEN_LO: begin g_mem = 1'b0; g_byte = w1_q[7:0];  end
						IDX_CK_HI:   begin g_mem = 1'b0; g_byte = ck_q[15:8]; end
						IDX_CK_LO:   begin g_mem = 1'b0; g_byte = ck_q[7:0];  end
						default: ;
					endcase
				end
			end
			G_OPT: begin
				g_v = 1'b1;
				case (idx_q[1:0])
					2'd0: g_byte = OPT_TYPE;
					2'd1: g_byte = OPT_LEN;
					2'd2: g_byte = alert_value[15:8];
					default: begin
						g_byte = alert_value[7:0];
						g_last = last_q;
					end
				endcase
			end
			default: ;
		endcase
	end

	// end-around carry folds of the header sum
	assign fold1 = {1'b0, sum_q[15:0]} + {10'd0, sum_q[22:16]};
	assign fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};

	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			hdr_mem[mem_wr.addr[AW-1:0]] <= mem_wr.data;
		end
		if (adv && g_rd) begin
			rd_s1 <= hdr_mem[idx_q[AW-1:0]];
		end
		if (adv) begin
			s1_mem  <= g_mem;
			s1_byte <= g_byte;
			s1_last <= g_last;
			s1_st   <= g_st;
			ob_q    <= s1_mem ? rd_s1 : s1_byte;
			ol_q    <= s1_last;
			os_q    <= s1_st;
		end
		if (q_pop && q_data.kind != CMD_PASS) begin
			cnt_q   <= q_data.count;
			trunc_q <= (q_data.kind == CMD_TRUNC);
			last_q  <= q_data.last;
			w0_q    <= q_data.w0;
			w1_q    <= q_data.w1;
			sum_q   <= 23'(q_data.acc) + 23'(q_data.w0) + 23'(q_data.w1) +
				23'({OPT_TYPE, OPT_LEN}) + 23'(alert_value);
		end
		ck_q <= ~fold2[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			idx_q   <= '0;
			s1_v    <= 1'b0;
			ov_q    <= 1'b0;
		end else if (adv) begin
			s1_v <= g_v;
			ov_q <= s1_v;
			unique case (state_q)
				G_IDLE: begin
					idx_q <= '0;
					if (q_pop && q_data.kind != CMD_PASS) begin
						state_q <= G_HDR;
					end
				end
				G_HDR: begin
					if (hdr_end) begin
						idx_q   <= '0;
						state_q <= trunc_q ? G_IDLE : G_OPT;
					end else begin
						idx_q <= idx_q + 6'd1;
					end
				end
				G_OPT: begin
					if (idx_q[1:0] == 2'd3) begin
						idx_q   <= '0;
						state_q <= G_IDLE;
					end else begin
						idx_q <= idx_q + 6'd1;
					end
				end
				default: begin
					idx_q   <= '0;
					state_q <= G_IDLE;
				end
			endcase
		end
	end

	assign pkt_out.valid    = ov_q;
	assign pkt_out.out_byte = ob_q;
	assign pkt_out.out_last = ol_q;
	assign pkt_out.status   = os_q;

endmodule

// ===== design/ipv4_router_alert_inserter.sv =====
// ----------------------------------------------------------------------------
// ipv4_router_alert_inserter
// IPv4 router alert option insertion on a byte stream.
// ----------------------------------------------------------------------------
// Payload bytes and passed-through packets move at one item per cycle unless
// the output or the full command queue holds them. Header bytes are buffered
// and give no output; once the header is complete it is sent out rewritten at
// one byte per cycle while the output accepts it, followed by the four option
// bytes. Input is taken meanwhile into a four-entry command queue, but the
// first byte of the next packet's header waits until the previous header has
// been read out of the header buffer. No clearing pass after reset.
module ipv4_router_alert_inserter
	import rai_pkg::*;
#(
	parameter int MAX_HEADER_BYTES = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	rai_in_if.sink      pkt_in,
	rai_out_if.source   pkt_out,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic [15:0] alert_q;
	mem_wr_t     mem_wr;
	logic        q_push, q_full, q_pop, q_empty;
	cmd_t        q_push_data, q_pop_data;
	logic        hdr_done, hdr_pending;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alert_q <= '0;
		end else if (cfg_we) begin
			alert_q <= cfg_wdata;
		end
	end

	rai_front #(
		.MAX_HEADER_BYTES(MAX_HEADER_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pkt_in     (pkt_in),
		.mem_wr     (mem_wr),
		.q_push     (q_push),
		.q_data     (q_push_data),
		.q_full     (q_full),
		.hdr_done   (hdr_done),
		.hdr_pending(hdr_pending)
	);

	rai_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_push_data),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_pop_data),
		.empty    (q_empty)
	);

	rai_back #(
		.MAX_HEADER_BYTES(MAX_HEADER_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pkt_out    (pkt_out),
		.mem_wr     (mem_wr),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.q_data     (q_pop_data),
		.alert_value(alert_q),
		.hdr_done   (hdr_done)
	);

`ifndef SYNTH
	a_q_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("command queue overflow");

	a_q_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("command queue underflow");

	a_no_wr_while_read: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr.en |-> !hdr_pending) else $error("header buffer overwritten");

	a_done_only_pending: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_done |-> hdr_pending) else $error("header done without header");
`endif

endmodule
